[design/gcqp_pkg.sv]
// Shared constants, codes and types of the glyph cache block.
package gcqp_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int SQ_W        = IDX_W + 2;
    localparam int I_W         = IDX_W + 1;
    localparam int CODE_W      = 21;
    localparam int MET_W       = 24;
    localparam int ENTRY_W     = CODE_W + MET_W;
    localparam int SLOT_W      = 8;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_HIT      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS     = 2'd3;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LEFT  = 5'b00010,
        S_RIGHT = 5'b00100,
        S_MATCH = 5'b01000,
        S_ADV   = 5'b10000
    } t_state;

endpackage

[design/glyph_cache_quadratic_probe_top.sv]
// Glyph cache table with quadratic probing: sequencer, valid bits and entry RAM.
//
// Usage:
//   Drive i_char_code, i_glyph_ok and the three metric inputs with start high;
//   the item is taken on a clock edge where busy is low. busy then stays high
//   until the result is ready. The result (o_status, o_slot, o_advance,
//   o_offset_x, o_offset_y) is shown for exactly one cycle with o_strobe high;
//   the receiver cannot stall and must take it in that cycle. busy is already
//   low in the strobe cycle, so the next item may be started there.
// Timing:
//   A probe of an occupied slot passes through an address/RAM read state and
//   a key compare state; a probe that finds an empty slot ends in its read
//   state, a side that falls outside the table and each step to the next
//   square use a state of their own, after the idle state takes the item.
//   For 256 slots the result comes soonest when the home slot is empty, then
//   on a hit at home, and latest on the longest chain (home slots 25 to 30
//   and 225 to 230); the next item can start in the strobe cycle.
//   The rate is set by the single RAM read port and the one shared adder.
// Reset:
//   i_rst_n low clears all valid bits at once and returns to idle; entry RAM
//   contents are not cleared and are never used before they are written.
module glyph_cache_quadratic_probe_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [gcqp_pkg::CODE_W-1:0]      i_char_code,
    input  logic                             i_glyph_ok,
    input  logic [7:0]                       i_new_advance,
    input  logic signed [7:0]                i_new_offset_x,
    input  logic signed [7:0]                i_new_offset_y,
    output logic                             o_strobe,
    output logic [gcqp_pkg::STATUS_W-1:0]    o_status,
    output logic [gcqp_pkg::SLOT_W-1:0]      o_slot,
    output logic [7:0]                       o_advance,
    output logic signed [7:0]                o_offset_x,
    output logic signed [7:0]                o_offset_y
);

    gcqp_pkg::t_state r_state, n_state;

    logic [gcqp_pkg::TABLE_SLOTS-1:0] r_valid;
    logic                             set_valid;
    logic [gcqp_pkg::IDX_W-1:0]       valid_idx;

    logic [gcqp_pkg::CODE_W-1:0]   r_code, n_code;
    logic                          r_ok, n_ok;
    logic [gcqp_pkg::MET_W-1:0]    r_metrics, n_metrics;
    logic [gcqp_pkg::I_W-1:0]      r_i, n_i;
    logic [gcqp_pkg::SQ_W-1:0]     r_sq, n_sq;
    logic                          r_left_out, n_left_out;
    logic                          r_from_left, n_from_left;
    logic [gcqp_pkg::IDX_W-1:0]    r_addr, n_addr;

    logic                          r_strobe, n_strobe;
    logic [gcqp_pkg::STATUS_W-1:0] r_status, n_status;
    logic [gcqp_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic [gcqp_pkg::MET_W-1:0]    r_out_met, n_out_met;

    gcqp_pkg::t_alu_op             alu_op;
    logic [gcqp_pkg::SQ_W-1:0]     alu_a, alu_b, alu_sum;
    logic                          alu_carry;
    logic [gcqp_pkg::IDX_W-1:0]    alu_addr;
    logic [gcqp_pkg::IDX_W-1:0]    home;

    logic                          ram_we;
    logic [gcqp_pkg::IDX_W-1:0]    ram_waddr;
    logic [gcqp_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [gcqp_pkg::CODE_W-1:0]   rd_code;
    logic [gcqp_pkg::MET_W-1:0]    rd_met;
    logic                          right_in;

    assign home     = r_code[gcqp_pkg::IDX_W-1:0];
    assign alu_addr = alu_sum[gcqp_pkg::IDX_W-1:0];
    assign rd_code  = ram_rdata[gcqp_pkg::ENTRY_W-1:gcqp_pkg::MET_W];
    assign rd_met   = ram_rdata[gcqp_pkg::MET_W-1:0];
    assign right_in = !alu_carry && (alu_sum[gcqp_pkg::SQ_W-1:gcqp_pkg::IDX_W] == '0);

    gcqp_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    gcqp_ram #(
        .WIDTH (gcqp_pkg::ENTRY_W),
        .DEPTH (gcqp_pkg::TABLE_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_code, r_metrics}),
        .i_raddr (alu_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_ok        = r_ok;
        n_metrics   = r_metrics;
        n_i         = r_i;
        n_sq        = r_sq;
        n_left_out  = r_left_out;
        n_from_left = r_from_left;
        n_addr      = r_addr;
        n_strobe    = 1'b0;
        n_status    = r_status;
        n_slot      = r_slot;
        n_out_met   = r_out_met;
        alu_op      = gcqp_pkg::ALU_SUB;
        alu_a       = gcqp_pkg::SQ_W'(home);
        alu_b       = r_sq;
        ram_we      = 1'b0;
        ram_waddr   = alu_addr;
        set_valid   = 1'b0;
        valid_idx   = alu_addr;

        unique case (r_state) inside
            gcqp_pkg::S_IDLE: begin
                if (start) begin
                    n_code     = i_char_code;
                    n_ok       = i_glyph_ok;
                    n_metrics  = {i_new_offset_y, i_new_offset_x, i_new_advance};
                    n_i        = '0;
                    n_sq       = '0;
                    n_left_out = 1'b0;
                    n_state    = gcqp_pkg::S_LEFT;
                end
            end
            gcqp_pkg::S_LEFT, gcqp_pkg::S_RIGHT: begin
                alu_op = (r_state == gcqp_pkg::S_LEFT) ? gcqp_pkg::ALU_SUB
                                                       : gcqp_pkg::ALU_ADD;
                if ((r_state == gcqp_pkg::S_LEFT) ? alu_carry : right_in) begin
                    if (r_valid[alu_addr]) begin
                        // occupied: read the entry and compare next cycle
                        n_from_left = (r_state == gcqp_pkg::S_LEFT);
                        n_addr      = alu_addr;
                        n_state     = gcqp_pkg::S_MATCH;
                    end else begin
                        n_strobe = 1'b1;
                        n_state  = gcqp_pkg::S_IDLE;
                        if (r_ok) begin
                            ram_we    = 1'b1;
                            set_valid = 1'b1;
                            n_status  = gcqp_pkg::ST_INSERTED;
                            n_slot    = gcqp_pkg::SLOT_W'(alu_addr);
                            n_out_met = r_metrics;
                        end else begin
                            n_status  = gcqp_pkg::ST_MISS;
                            n_slot    = '0;
                            n_out_met = '0;
                        end
                    end
                end else if (r_state == gcqp_pkg::S_LEFT) begin
                    n_left_out = 1'b1;
                    n_state    = gcqp_pkg::S_RIGHT;
                end else if (r_left_out) begin
                    // both sides out of the table: overwrite home if the glyph is ok, else report a miss
                    n_strobe  = 1'b1;
                    n_state   = gcqp_pkg::S_IDLE;
                    ram_waddr = home;
                    valid_idx = home;
                    if (r_ok) begin
                        ram_we    = 1'b1;
                        set_valid = 1'b1;
                        n_status  = gcqp_pkg::ST_REPLACED;
                        n_slot    = gcqp_pkg::SLOT_W'(home);
                        n_out_met = r_metrics;
                    end else begin
                        n_status  = gcqp_pkg::ST_MISS;
                        n_slot    = '0;
                        n_out_met = '0;
                    end
                end else begin
                    n_state = gcqp_pkg::S_ADV;
                end
            end
            gcqp_pkg::S_MATCH: begin
                if (rd_code == r_code) begin
                    n_strobe  = 1'b1;
                    n_state   = gcqp_pkg::S_IDLE;
                    n_status  = gcqp_pkg::ST_HIT;
                    n_slot    = gcqp_pkg::SLOT_W'(r_addr);
                    n_out_met = rd_met;
                end else if (r_from_left && (r_i != '0)) begin
                    n_state = gcqp_pkg::S_RIGHT;
                end else begin
                    // after the right probe advance; at step zero both sides are the home slot: skip the repeat
                    n_state = gcqp_pkg::S_ADV;
                end
            end
            gcqp_pkg::S_ADV: begin
                // (i+1)^2 = i^2 + 2i + 1
                alu_op     = gcqp_pkg::ALU_ADD;
                alu_a      = r_sq;
                alu_b      = gcqp_pkg::SQ_W'({r_i, 1'b1});
                n_sq       = alu_sum;
                n_i        = r_i + gcqp_pkg::I_W'(1);
                n_left_out = 1'b0;
                n_state    = gcqp_pkg::S_LEFT;
            end
            default: begin
                n_state = gcqp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gcqp_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (set_valid) begin
                r_valid[valid_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code      <= n_code;
        r_ok        <= n_ok;
        r_metrics   <= n_metrics;
        r_i         <= n_i;
        r_sq        <= n_sq;
        r_left_out  <= n_left_out;
        r_from_left <= n_from_left;
        r_addr      <= n_addr;
        r_status    <= n_status;
        r_slot      <= n_slot;
        r_out_met   <= n_out_met;
    end

    assign busy       = (r_state != gcqp_pkg::S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_slot     = r_slot;
    assign o_advance  = r_out_met[7:0];
    assign o_offset_x = r_out_met[15:8];
    assign o_offset_y = r_out_met[23:16];

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == gcqp_pkg::ST_MISS)) |->
            (o_slot == '0 && o_advance == '0 && o_offset_x == '0 && o_offset_y == '0))
        else $error("miss result carries nonzero fields");

endmodule

[design/gcqp_ram.sv]
// Generic single-port-write, registered-read RAM.
module gcqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/gcqp_alu.sv]
// Shared adder/subtractor for probe addresses and the running square.
module gcqp_alu (
    input  gcqp_pkg::t_alu_op          i_op,
    input  logic [gcqp_pkg::SQ_W-1:0] i_a,
    input  logic [gcqp_pkg::SQ_W-1:0] i_b,
    output logic [gcqp_pkg::SQ_W-1:0] o_sum,
    output logic                       o_carry
);

    logic [gcqp_pkg::SQ_W-1:0] b_eff;
    logic                      cin;

    always_comb begin
        b_eff = (i_op == gcqp_pkg::ALU_SUB) ? ~i_b : i_b;
        cin   = (i_op == gcqp_pkg::ALU_SUB);
        {o_carry, o_sum} = {1'b0, i_a} + {1'b0, b_eff} + {{gcqp_pkg::SQ_W{1'b0}}, cin};
    end

endmodule
